FILE: rtl/closest_value_binary_search_top_macros.svh
// Assertion macros shared by the nearest-value search RTL.
`ifndef CLOSEST_VALUE_BINARY_SEARCH_TOP_MACROS_SVH
`define CLOSEST_VALUE_BINARY_SEARCH_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CVBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cvbs assertion failed");
`define CVBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cvbs assertion failed");
`else
`define CVBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CVBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/cvbs_pkg.sv
// Shared constants, types and helpers of the nearest-value search block.
package cvbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int POS_W       = ADDR_W + 2;
    localparam int TIME_W      = 32;
    localparam int IDX_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 16;

    localparam logic [TIME_W-1:0] TOL_RESET = 32'd655;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INDEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd2;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic wr_entry;
        logic load_search;
        logic set_miss;
        logic rd_mid;
        logic cmp;
        logic rd_prev;
        logic rd_next;
        logic pick;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic miss;
        logic probe_ok;
        logic hit;
        logic out_free;
    } t_sts;

    function automatic logic [TIME_W-1:0] abs_diff(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

FILE: rtl/cvbs_datapath.sv
// Datapath: timestamp table, config registers, bisection bounds and result register.
`include "closest_value_binary_search_top_macros.svh"

module cvbs_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cvbs_pkg::t_cmd                   i_cmd,
    output cvbs_pkg::t_sts                   o_sts,
    input  logic [cvbs_pkg::S_DATA_W-1:0]    i_s_tdata,
    input  logic                             i_cfg_valid,
    input  logic [cvbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cvbs_pkg::TIME_W-1:0]      i_cfg_data,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [cvbs_pkg::M_DATA_W-1:0]    o_m_tdata,
    output logic                             o_m_tuser
);

    logic [cvbs_pkg::TIME_W-1:0] r_mem [cvbs_pkg::TABLE_DEPTH];
    logic [cvbs_pkg::TIME_W-1:0] r_rdata;

    logic [cvbs_pkg::ADDR_W-1:0] r_first_index;
    logic [cvbs_pkg::CNT_W-1:0]  r_entry_count;
    logic [cvbs_pkg::TIME_W-1:0] r_tolerance;

    logic [cvbs_pkg::TIME_W-1:0]       r_query;
    logic signed [cvbs_pkg::POS_W-1:0] r_lo;
    logic signed [cvbs_pkg::POS_W-1:0] r_up;
    logic [cvbs_pkg::ADDR_W-1:0]       r_probe;
    logic [cvbs_pkg::TIME_W-1:0]       r_dprobe;
    logic [cvbs_pkg::TIME_W-1:0]       r_dprev;
    logic [cvbs_pkg::IDX_W-1:0]        r_res_idx;
    logic                              r_res_miss;
    logic                              r_out_valid;
    logic [cvbs_pkg::IDX_W-1:0]        r_out_idx;
    logic                              r_out_miss;

    logic [cvbs_pkg::ADDR_W-1:0]       w_in_idx;
    logic [cvbs_pkg::TIME_W-1:0]       w_in_time;
    logic [cvbs_pkg::CNT_W-1:0]        w_up0;
    logic [cvbs_pkg::CNT_W-1:0]        w_up0_m1;
    logic [cvbs_pkg::ADDR_W-1:0]       w_hi_lim;
    logic signed [cvbs_pkg::POS_W-1:0] w_lo_lim;
    logic signed [cvbs_pkg::POS_W-1:0] w_hi_lim_s;
    logic signed [cvbs_pkg::POS_W:0]   w_sum;
    logic signed [cvbs_pkg::POS_W-1:0] w_mid;
    logic signed [cvbs_pkg::POS_W-1:0] w_probe_s;
    logic [cvbs_pkg::ADDR_W-1:0]       w_prev;
    logic [cvbs_pkg::ADDR_W-1:0]       w_next;
    logic [cvbs_pkg::ADDR_W-1:0]       w_rd_addr;
    logic                              w_rd_en;
    logic [cvbs_pkg::TIME_W-1:0]       w_dcur;
    logic [cvbs_pkg::TIME_W-1:0]       w_dnext;
    logic [cvbs_pkg::ADDR_W-1:0]       w_pick;

    assign w_in_idx  = i_s_tdata[cvbs_pkg::ADDR_W-1:0];
    assign w_in_time = i_s_tdata[cvbs_pkg::IDX_W +: cvbs_pkg::TIME_W];

    // Saturate the exclusive upper bound at the table depth.
    assign w_up0 = (r_entry_count > cvbs_pkg::CNT_W'(cvbs_pkg::TABLE_DEPTH))
                 ? cvbs_pkg::CNT_W'(cvbs_pkg::TABLE_DEPTH) : r_entry_count;
    assign w_up0_m1   = w_up0 - cvbs_pkg::CNT_W'(1);
    assign w_hi_lim   = w_up0_m1[cvbs_pkg::ADDR_W-1:0];
    assign w_lo_lim   = $signed({2'b00, r_first_index});
    assign w_hi_lim_s = $signed({2'b00, w_hi_lim});
    assign w_probe_s  = $signed({2'b00, r_probe});

    assign w_sum = {r_lo[cvbs_pkg::POS_W-1], r_lo} + {r_up[cvbs_pkg::POS_W-1], r_up};
    assign w_mid = w_sum[cvbs_pkg::POS_W:1];

    assign w_prev = (r_probe == r_first_index) ? r_probe : r_probe - 1'b1;
    assign w_next = (r_probe == w_hi_lim) ? r_probe : r_probe + 1'b1;

    assign w_dcur  = cvbs_pkg::abs_diff(r_rdata, r_query);
    assign w_dnext = w_dcur;

    // Ties favor the previous entry, then the next entry over the probe.
    always_comb begin
        if (r_dprev <= w_dnext) begin
            w_pick = (r_dprev <= r_dprobe) ? w_prev : r_probe;
        end else begin
            w_pick = (w_dnext <= r_dprobe) ? w_next : r_probe;
        end
    end

    always_comb begin
        priority if (i_cmd.rd_mid) begin
            w_rd_addr = w_mid[cvbs_pkg::ADDR_W-1:0];
        end else if (i_cmd.rd_prev) begin
            w_rd_addr = w_prev;
        end else begin
            w_rd_addr = w_next;
        end
    end
    assign w_rd_en = i_cmd.rd_mid | i_cmd.rd_prev | i_cmd.rd_next;

    assign o_sts.miss     = (r_query == '0) || (w_up0 <= {1'b0, r_first_index});
    assign o_sts.probe_ok = (r_lo <= r_up) && (w_mid >= w_lo_lim) && (w_mid <= w_hi_lim_s);
    assign o_sts.hit      = (w_dcur <= r_tolerance);
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry) begin
            r_mem[w_in_idx] <= w_in_time;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_index <= '0;
            r_entry_count <= '0;
            r_tolerance   <= cvbs_pkg::TOL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cvbs_pkg::CFG_FIRST_INDEX: r_first_index <= i_cfg_data[cvbs_pkg::ADDR_W-1:0];
                cvbs_pkg::CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[cvbs_pkg::CNT_W-1:0];
                cvbs_pkg::CFG_TOLERANCE:   r_tolerance   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_search) begin
            r_query <= w_in_time;
            r_lo    <= w_lo_lim;
            r_up    <= $signed({1'b0, w_up0});
        end else if (i_cmd.cmp && !o_sts.hit) begin
            if (r_query > r_rdata) begin
                r_lo <= w_probe_s + cvbs_pkg::POS_W'(1);
            end else begin
                r_up <= w_probe_s - cvbs_pkg::POS_W'(1);
            end
        end
        if (i_cmd.rd_mid) begin
            r_probe <= w_mid[cvbs_pkg::ADDR_W-1:0];
        end
        if (i_cmd.cmp) begin
            r_dprobe <= w_dcur;
        end
        if (i_cmd.rd_next) begin
            r_dprev <= w_dcur;
        end
        if (i_cmd.set_miss) begin
            r_res_idx  <= '0;
            r_res_miss <= 1'b1;
        end else if (i_cmd.pick) begin
            r_res_idx  <= cvbs_pkg::IDX_W'(w_pick);
            r_res_miss <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_idx  <= r_res_idx;
            r_out_miss <= r_res_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(cvbs_pkg::M_DATA_W - cvbs_pkg::IDX_W){1'b0}}, r_out_idx};
    assign o_m_tuser  = r_out_miss;

    `CVBS_ASSERT_IMP(a_prev_in_range, i_clk, i_rst_n, i_cmd.rd_prev,
        (r_probe >= r_first_index) && (r_probe <= w_hi_lim))
    `CVBS_ASSERT_IMP(a_miss_zero_idx, i_clk, i_rst_n, o_m_tvalid && o_m_tuser,
        r_out_idx == '0)

endmodule

FILE: rtl/cvbs_ctrl.sv
// Controller: sequences table writes, bisection probes, neighbor reads and result hand-off.
`include "closest_value_binary_search_top_macros.svh"

module cvbs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_s_tuser,
    output logic           o_s_tready,
    input  cvbs_pkg::t_sts i_sts,
    output cvbs_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_NEXT  = 3'd4;
    localparam logic [2:0] S_PICK  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == cvbs_pkg::ACT_SEARCH) begin
                        o_cmd.load_search = 1'b1;
                        n_state = S_CHECK;
                    end else begin
                        o_cmd.wr_entry = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.miss) begin
                    o_cmd.set_miss = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                // Bisection left the range: keep the last probe.
                if (i_sts.probe_ok) begin
                    o_cmd.rd_mid = 1'b1;
                    n_state = S_CMP;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.rd_prev = 1'b1;
                    n_state = S_NEXT;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_NEXT: begin
                o_cmd.rd_next = 1'b1;
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `CVBS_ASSERT_NXT(a_miss_to_out, i_clk, i_rst_n, (r_state == S_CHECK) && i_sts.miss,
        r_state == S_OUT)
    `CVBS_ASSERT_IMP(a_cmp_after_probe, i_clk, i_rst_n, r_state == S_CMP,
        $past(r_state) == S_PROBE)
    `CVBS_ASSERT_IMP(a_emit_when_free, i_clk, i_rst_n, o_cmd.emit, i_sts.out_free)

endmodule

FILE: rtl/closest_value_binary_search_top.sv
// Top level of the nearest-value search block: controller, datapath and port wiring.
//
// Holds a 1024-entry table of ascending unsigned Q16.16 timestamps and answers nearest-value
// queries. An input transaction with tuser = 0 writes tdata's time into the table entry given
// by tdata's index; writes may follow back to back. A transaction with tuser = 1 searches
// for the query time over [first_index, entry_count) and returns one result transaction:
// the index of the nearest of the final probe and its two neighbors, or a miss (tuser = 1,
// index 0) for a zero query or an empty range. A search makes at most 11 probes over the
// full table. Each probe reads the table in the probe state and is compared in the compare
// state, as the table has one registered read port and the comparison waits for its data.
// One search is in flight at a time; the result register lets the next transaction be
// accepted while a result still waits. Configuration writes are taken at once (o_cfg_ready
// is always high) and must only be issued while no search is in progress.

module closest_value_binary_search_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [cvbs_pkg::S_DATA_W-1:0]    i_s_tdata,   // [9:0] entry_index, [41:10] time_value
    input  logic                             i_s_tuser,   // [0] action
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [cvbs_pkg::M_DATA_W-1:0]    o_m_tdata,   // [9:0] closest_index
    output logic                             o_m_tuser,   // [0] miss
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cvbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cvbs_pkg::TIME_W-1:0]      i_cfg_data
);

    cvbs_pkg::t_cmd w_cmd;
    cvbs_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    cvbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cvbs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the nearest-timestamp search block over its streaming ports.
`timescale 1ns / 100ps

module testbench;
    import cvbs_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 250;
    localparam int QUIET_ITEMS   = 50;
    // Only these two blocks of the table are ever written; searches stay inside them
    localparam int LOW_SPAN      = 160;
    localparam int HIGH_BASE     = TABLE_DEPTH - 64;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic             miss;
    } lookup_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata = '0;
    logic                  i_s_tuser = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [TIME_W-1:0]     i_cfg_data = '0;

    // Shadow of the block's table and registers
    logic [TIME_W-1:0]  time_mem [TABLE_DEPTH];
    logic [IDX_W-1:0]   first_index = '0;
    logic [CNT_W-1:0]   entry_count = '0;
    logic [TIME_W-1:0]  tolerance = TOL_RESET;

    lookup_t nearest_due[$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      stall_left = 0;
    bit      quiet = 1'b0;

    closest_value_binary_search_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL closest_value_binary_search_top");
            $finish;
        end
    end

    function automatic logic [TIME_W-1:0] spacing(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic int written_index();
        if ($urandom_range(0, 1) == 0)
            return int'($urandom_range(0, LOW_SPAN - 1));
        return int'($urandom_range(HIGH_BASE, TABLE_DEPTH - 1));
    endfunction

    // Bisect the shadow table, then pick the nearest of the last probe and its neighbors
    function automatic lookup_t nearest_entry(input logic [TIME_W-1:0] query);
        int lo_lim, hi_lim, lo, up, mid, probe, prev, next;
        logic [TIME_W-1:0] t, d_prev, d_next, d_probe;
        lookup_t r;
        r.index = '0;
        r.miss  = 1'b1;
        lo_lim = int'(first_index);
        up = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
        if (query == '0 || up <= lo_lim)
            return r;
        hi_lim = up - 1;
        lo = lo_lim;
        probe = (lo + up) / 2;
        while (lo <= up) begin
            mid = (lo + up) / 2;
            if (mid < lo_lim || mid > hi_lim)
                break;
            probe = mid;
            t = time_mem[mid];
            if (spacing(t, query) <= tolerance)
                break;
            if (query > t)
                lo = mid + 1;
            else
                up = mid - 1;
        end
        prev = (probe - 1 < lo_lim) ? lo_lim : probe - 1;
        next = (probe + 1 > hi_lim) ? hi_lim : probe + 1;
        d_prev  = spacing(query, time_mem[prev]);
        d_next  = spacing(query, time_mem[next]);
        d_probe = spacing(query, time_mem[probe]);
        r.miss = 1'b0;
        if (d_prev <= d_next)
            r.index = IDX_W'((d_prev <= d_probe) ? prev : probe);
        else
            r.index = IDX_W'((d_next <= d_probe) ? next : probe);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Result side: pace the ready and check every result transaction
    always @(negedge i_clk) begin : sink_pace
        logic ready_next;
        ready_next = 1'b1;
        if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            ready_next = 1'b0;
        end
        i_m_tready <= ready_next;
    end

    always @(posedge i_clk) begin : result_check
        lookup_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (nearest_due.size() == 0) begin
                report_mismatch("result with none pending, index", o_m_tdata[IDX_W-1:0], 0);
            end else begin
                want = nearest_due.pop_front();
                if (o_m_tuser !== want.miss)
                    report_mismatch("miss flag", o_m_tuser, want.miss);
                if (o_m_tdata[IDX_W-1:0] !== want.index)
                    report_mismatch("closest index", o_m_tdata[IDX_W-1:0], want.index);
            end
        end
    end

    task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                             input logic [TIME_W-1:0] tv);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {{(S_DATA_W - IDX_W - TIME_W){1'b0}}, tv, idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (act == ACT_WRITE)
            time_mem[idx] = tv;
        else
            nearest_due.push_back(nearest_entry(tv));
    endtask

    task automatic search(input logic [TIME_W-1:0] query);
        send_item(ACT_SEARCH, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), query);
    endtask

    // Drain outstanding results and let any write finish before touching registers
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (nearest_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [TIME_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_FIRST_INDEX: first_index = data[IDX_W-1:0];
            CFG_ENTRY_COUNT: entry_count = data[CNT_W-1:0];
            CFG_TOLERANCE:   tolerance   = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_range(input int lo, input int count);
        write_reg(CFG_FIRST_INDEX, TIME_W'(lo));
        write_reg(CFG_ENTRY_COUNT, TIME_W'(count));
    endtask

    // Registers at reset leave an empty range: every search is a miss
    task automatic test_reset_misses();
        search('0);
        search(32'd1);
        search(32'hFFFF_FFFF);
        search($urandom());
        settle();
    endtask

    task automatic test_table_fill();
        logic [TIME_W-1:0] value;
        value = '0;
        for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
            if (i < LOW_SPAN || i >= HIGH_BASE) begin
                send_item(ACT_WRITE, IDX_W'(i), value);
                value = value + $urandom_range(0, 4_000_000);
            end
        end
        send_item(ACT_WRITE, IDX_W'(TABLE_DEPTH - 1), 32'hFFFF_FFFF);
        settle();
    endtask

    task automatic test_range_limits();
        set_range(0, LOW_SPAN);
        search(32'd1);
        search(32'hFFFF_FFFF);
        search(time_mem[LOW_SPAN / 2] + 32'd600);    // inside the reset tolerance
        search('0);
        settle();
        set_range(HIGH_BASE, 2047);   // count saturates at the table depth
        search(time_mem[HIGH_BASE + 20] + 32'd3);
        settle();
        set_range(TABLE_DEPTH - 1, TABLE_DEPTH);
        search($urandom());
        settle();
        write_reg(CFG_ENTRY_COUNT, TABLE_DEPTH - 1);
        search($urandom());
        settle();
        set_range(0, 1);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        search($urandom());
        settle();
    endtask

    task automatic test_tolerance_and_ties();
        write_reg(CFG_TOLERANCE, '0);
        set_range(10, 13);
        send_item(ACT_WRITE, 10'd10, 32'd100);
        send_item(ACT_WRITE, 10'd11, 32'd200);
        send_item(ACT_WRITE, 10'd12, 32'd300);
        search(32'd150);
        search(32'd250);
        search(32'd100);
        search(32'd300);
        search(32'd50);
        search(32'd400);
        settle();
        // Widest tolerance stops at the first probe
        write_reg(CFG_TOLERANCE, 32'hFFFF_FFFF);
        set_range(0, LOW_SPAN);
        search($urandom());
        settle();
    endtask

    task automatic test_random_traffic();
        int sent, phase_items, lo, up, idx, span, off, lo_cfg, up_cfg, blk_lo, blk_up;
        logic [TIME_W-1:0] tv, low_v, high_v;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            settle();
            if ($urandom_range(0, 1) == 0) begin
                blk_lo = 0;
                blk_up = LOW_SPAN;
            end else begin
                blk_lo = HIGH_BASE;
                blk_up = TABLE_DEPTH;
            end
            lo_cfg = $urandom_range(blk_lo, blk_up - 1);
            up_cfg = $urandom_range(lo_cfg + 1, blk_up);
            case ($urandom_range(0, 9))
                0, 1, 2: set_range(blk_lo, blk_up);
                3, 4: begin
                    up_cfg = lo_cfg + $urandom_range(1, 8);
                    set_range(lo_cfg, (up_cfg > blk_up) ? blk_up : up_cfg);
                end
                5, 6:    set_range(lo_cfg, up_cfg);
                7:       set_range($urandom_range(HIGH_BASE, TABLE_DEPTH - 1),
                                   $urandom_range(TABLE_DEPTH + 1, 2047));
                8:       set_range(lo_cfg, $urandom_range(0, lo_cfg));
                default: begin
                    // upper data bits are dropped by the register widths
                    write_reg(CFG_FIRST_INDEX, ($urandom() & 32'hFFFF_FC00) | TIME_W'(lo_cfg));
                    write_reg(CFG_ENTRY_COUNT, ($urandom() & 32'hFFFF_F800) | TIME_W'(up_cfg));
                end
            endcase
            case ($urandom_range(0, 7))
                0:       write_reg(CFG_TOLERANCE, '0);
                1:       write_reg(CFG_TOLERANCE, $urandom_range(0, 1000));
                2:       write_reg(CFG_TOLERANCE, $urandom_range(0, 1 << 20));
                3:       write_reg(CFG_TOLERANCE, 32'hFFFF_FFFF);
                4:       write_reg(CFG_TOLERANCE, $urandom());
                default: ;
            endcase
            lo = int'(first_index);
            up = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
            phase_items = $urandom_range(20, 60);
            repeat (phase_items) begin
                if (up > lo && $urandom_range(0, 9) < 7)
                    idx = $urandom_range(lo, up - 1);
                else
                    idx = written_index();
                if ($urandom_range(0, 9) < 3) begin
                    // mostly keep the table ascending around the written entry
                    low_v  = (idx > 0 && idx != HIGH_BASE) ? time_mem[idx - 1] : '0;
                    high_v = (idx < TABLE_DEPTH - 1 && idx != LOW_SPAN - 1)
                           ? time_mem[idx + 1] : 32'hFFFF_FFFF;
                    if (low_v <= high_v && $urandom_range(0, 9) != 0)
                        tv = $urandom_range(low_v, high_v);
                    else
                        tv = $urandom();
                    send_item(ACT_WRITE, IDX_W'(idx), tv);
                end else begin
                    span = 1 << $urandom_range(0, 24);
                    off = $urandom_range(0, span);
                    case ($urandom_range(0, 19))
                        0:          tv = '0;
                        1:          tv = 32'hFFFF_FFFF;
                        2, 3, 4:    tv = $urandom();
                        5, 6, 7, 8, 9: tv = time_mem[idx];
                        default: begin
                            if ($urandom_range(0, 1) == 1)
                                tv = time_mem[idx] + TIME_W'(off);
                            else
                                tv = time_mem[idx] - TIME_W'(off);
                        end
                    endcase
                    search(tv);
                end
                sent++;
            end
        end
        settle();
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_misses();
        test_table_fill();
        test_range_limits();
        test_tolerance_and_ties();
        test_random_traffic();
        while (nearest_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS closest_value_binary_search_top");
        else
            $display("FAIL closest_value_binary_search_top");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cvbs_pkg.sv
rtl/cvbs_datapath.sv
rtl/cvbs_ctrl.sv
rtl/closest_value_binary_search_top.sv
test/testbench.sv
